// File: rtl/core/slcm_pkg.sv
// ----------------------------------------------------------------------------
// slcm_pkg
// Shared widths, types and command/status groups for the saturating LCM block.
// ----------------------------------------------------------------------------
package slcm_pkg;

  localparam int DATA_W = 64;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    logic load;
    logic div_gcd;
    logic div_quo;
    logic div_step;
    logic swap;
    logic mul_start;
    logic mul_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic any_zero;
    logic y_zero;
    logic step_last;
  } status_t;

endpackage

// File: rtl/core/slcm_ifs.sv
// ----------------------------------------------------------------------------
// slcm_ifs
// Valid/ready channels for operand requests and LCM results.
// ----------------------------------------------------------------------------
interface slcm_in_if;
  logic            valid;
  logic            ready;
  slcm_pkg::word_t operand_a;
  slcm_pkg::word_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface slcm_out_if;
  logic            valid;
  logic            ready;
  slcm_pkg::word_t lcm_value;

  modport source (output valid, output lcm_value, input ready);
  modport sink   (input valid, input lcm_value, output ready);
endinterface

// File: rtl/core/saturating_lcm_u64_top.sv
// ----------------------------------------------------------------------------
// saturating_lcm_u64_top
// Saturating least common multiple of two unsigned 64-bit operands.
//
//   channel    dir   payload                  handshake
//   operands   in    operand_a, operand_b     valid / ready
//   result     out   lcm_value                valid / ready
//
// Each request runs k Euclid remainder steps (k at most 92), one pass of the
// shared bit-serial divider per step, then one more pass for the exact
// quotient and a shift-add multiply; a zero operand goes straight to the
// result. A new request is taken once the previous one is in the result
// register, even if that result is still waiting. Reset (rst, synchronous)
// drops any request in flight and clears result valid.
// ----------------------------------------------------------------------------
module saturating_lcm_u64_top (
  input logic        clk,
  input logic        rst,
  slcm_in_if.sink    operands,
  slcm_out_if.source result
);

  slcm_pkg::cmd_t    cmd;
  slcm_pkg::status_t status;

  slcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  slcm_datapath u_datapath (
    .clk       (clk),
    .operand_a (operands.operand_a),
    .operand_b (operands.operand_b),
    .cmd       (cmd),
    .status    (status),
    .lcm_value (result.lcm_value)
  );

endmodule

// File: rtl/core/slcm_datapath.sv
// ----------------------------------------------------------------------------
// slcm_datapath
// Operand registers, shared restoring divider, shift-add multiplier with
// overflow tracking, and the result register.
// ----------------------------------------------------------------------------
module slcm_datapath (
  input  logic                 clk,
  input  slcm_pkg::word_t      operand_a,
  input  slcm_pkg::word_t      operand_b,
  input  slcm_pkg::cmd_t       cmd,
  output slcm_pkg::status_t    status,
  output slcm_pkg::word_t      lcm_value
);

  localparam int W = slcm_pkg::DATA_W;

  slcm_pkg::word_t  x;
  slcm_pkg::word_t  y;
  slcm_pkg::word_t  opa;
  slcm_pkg::word_t  opb;
  slcm_pkg::word_t  rem;
  slcm_pkg::word_t  quo;
  slcm_pkg::word_t  dvs;
  slcm_pkg::word_t  acc;
  slcm_pkg::count_t cnt;
  logic             zero;
  logic             ovf;

  logic [W:0]       trial;
  slcm_pkg::word_t  rem_next;
  slcm_pkg::word_t  quo_next;
  slcm_pkg::word_t  addend;
  logic [W:0]       mac;
  slcm_pkg::word_t  acc_next;
  logic             ovf_next;

  always_comb begin
    trial = {rem, quo[W-1]} - {1'b0, dvs};
    if (!trial[W]) begin
      rem_next = trial[W-1:0];
      quo_next = {quo[W-2:0], 1'b1};
    end else begin
      rem_next = {rem[W-2:0], quo[W-1]};
      quo_next = {quo[W-2:0], 1'b0};
    end
  end

  always_comb begin
    addend   = quo[W-1] ? opb : '0;
    mac      = {1'b0, acc[W-2:0], 1'b0} + {1'b0, addend};
    acc_next = mac[W-1:0];
    ovf_next = ovf | acc[W-1] | mac[W];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= operand_a;
      y    <= operand_b;
      opa  <= operand_a;
      opb  <= operand_b;
      zero <= (operand_a == '0) || (operand_b == '0);
    end
    if (cmd.div_gcd) begin
      rem <= '0;
      quo <= x;
      dvs <= y;
      cnt <= '0;
    end
    if (cmd.div_quo) begin
      rem <= '0;
      quo <= opa;
      dvs <= x;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + slcm_pkg::CNT_W'(1);
    end
    if (cmd.swap) begin
      x <= y;
      y <= rem;
    end
    if (cmd.mul_start) begin
      acc <= '0;
      ovf <= 1'b0;
      cnt <= '0;
    end
    if (cmd.mul_step) begin
      quo <= {quo[W-2:0], 1'b0};
      acc <= acc_next;
      ovf <= ovf_next;
      cnt <= cnt + slcm_pkg::CNT_W'(1);
    end
    if (cmd.res_load) begin
      lcm_value <= zero ? '0 : (ovf ? '1 : acc);
    end
  end

  assign status.any_zero  = zero;
  assign status.y_zero    = (y == '0);
  assign status.step_last = (cnt == '1);

endmodule

// File: rtl/core/slcm_ctrl.sv
// ----------------------------------------------------------------------------
// slcm_ctrl
// Sequencer for Euclid iterations, exact division, multiply and result hand-off.
// ----------------------------------------------------------------------------
module slcm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output slcm_pkg::cmd_t    cmd,
  input  slcm_pkg::status_t status
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_GCD_DIV  = 4'd2;
  localparam logic [3:0] S_GCD_NEXT = 4'd3;
  localparam logic [3:0] S_GCD_TEST = 4'd4;
  localparam logic [3:0] S_Q_DIV    = 4'd5;
  localparam logic [3:0] S_MUL_INIT = 4'd6;
  localparam logic [3:0] S_MUL      = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.any_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_gcd = 1'b1;
          state_next  = S_GCD_DIV;
        end
      end
      S_GCD_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) state_next = S_GCD_NEXT;
      end
      S_GCD_NEXT: begin
        cmd.swap   = 1'b1;
        state_next = S_GCD_TEST;
      end
      S_GCD_TEST: begin
        if (status.y_zero) begin
          cmd.div_quo = 1'b1;
          state_next  = S_Q_DIV;
        end else begin
          cmd.div_gcd = 1'b1;
          state_next  = S_GCD_DIV;
        end
      end
      S_Q_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) state_next = S_MUL_INIT;
      end
      S_MUL_INIT: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted request did not advance to operand check");

  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result valid rose outside finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.mul_step))
    else $error("divider and multiplier stepped together");

endmodule

// File: bench/tb_saturating_lcm_u64_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_saturating_lcm_u64_top
// Drives operand requests into the saturating LCM block and checks each
// lcm_value against a local Euclid-based predictor, in order. Covers zero
// operands, exact boundaries, overflow, worst-case Euclid chains and random
// operands under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_saturating_lcm_u64_top;

  localparam bit [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] FIB_93        = 64'd12200160415121876738;
  localparam bit [63:0] FIB_92        = 64'd7540113804746346429;
  localparam bit [63:0] FIB_91        = 64'd4660046610375530309;
  localparam int        RANDOM_ITEMS  = 370;
  localparam int        DRAIN_CYCLES  = 6400;
  localparam longint    RUN_LIMIT     = 64'd40_000_000;

  logic clk;
  logic rst;

  slcm_in_if  operands_if ();
  slcm_out_if result_if ();

  saturating_lcm_u64_top DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_if),
    .result   (result_if)
  );

  bit [63:0] expected_lcm_q[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  longint    cycle_count;

  always #1 clk = ~clk;

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    operands_if.valid     = 1'b0;
    operands_if.operand_a = '0;
    operands_if.operand_b = '0;
    result_if.ready       = 1'b0;
    error_count           = 0;
    cycle_count           = 0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_saturating_lcm_u64_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit [63:0] lcm_saturating(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] x;
    bit [63:0] y;
    bit [63:0] r;
    bit [63:0] quotient;
    if (a == 0 || b == 0) return 64'd0;
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    quotient = a / x;
    if (quotient > ALL_ONES / b) return ALL_ONES;
    return quotient * b;
  endfunction

  always @(posedge clk) begin
    bit [63:0] expected;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_lcm_q.size() == 0) begin
        $error("lcm_value unexpected: expected none, actual %h", result_if.lcm_value);
        error_count++;
      end else begin
        expected = expected_lcm_q.pop_front();
        if (result_if.lcm_value !== expected) begin
          $error("lcm_value mismatch: expected %h, actual %h", expected,
                 result_if.lcm_value);
          error_count++;
        end
      end
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_request(input bit [63:0] a, input bit [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      operands_if.valid <= 1'b0;
      @(negedge clk);
    end
    operands_if.valid     <= 1'b1;
    operands_if.operand_a <= a;
    operands_if.operand_b <= b;
    do @(posedge clk); while (!operands_if.ready);
    expected_lcm_q.push_back(lcm_saturating(a, b));
    @(negedge clk);
  endtask

  function automatic bit [63:0] random_operand(input int unsigned max_width);
    bit [63:0]   v;
    int unsigned w;
    v = {$urandom, $urandom};
    w = $urandom_range(max_width, 1);
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  task automatic test_zero_operand();
    send_request(64'd0, 64'd0);
    send_request(64'd0, ALL_ONES);
    send_request(ALL_ONES, 64'd0);
    send_request(64'd0, 64'd12345);
  endtask

  task automatic test_exact_boundaries();
    send_request(64'd1, 64'd1);
    send_request(64'd1, ALL_ONES);
    send_request(ALL_ONES, 64'd1);
    send_request(ALL_ONES, ALL_ONES);
    send_request(64'd6, 64'd4);
    send_request(64'd12, 64'd18);
    send_request(64'h8000_0000_0000_0000, 64'd2);
    send_request(64'hFFFF_FFFF, 64'h1_0000_0001);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_overflow();
    send_request(ALL_ONES, ALL_ONES - 64'd1);
    send_request(64'h8000_0000_0000_0000, 64'd3);
    send_request(64'h1_0000_0000, 64'h1_0000_0001);
    send_request(FIB_93, FIB_92);
    send_request(FIB_92, FIB_93);
    send_request(FIB_92, FIB_91);
    send_request(64'd89, 64'd55);
  endtask

  task automatic test_random(input int n, input int send_pct, input int recv_pct);
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] common;
    int        kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        a = 64'd0;
        b = random_operand(64);
        if ($urandom_range(1)) begin
          a = b;
          b = 64'd0;
        end
      end else if (kind <= 3) begin
        common = random_operand(24);
        a = common * random_operand(24);
        b = common * random_operand(24);
      end else begin
        a = random_operand(64);
        b = random_operand(64);
      end
      send_request(a, b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 73;
    test_zero_operand();
    test_exact_boundaries();
    test_overflow();
    test_random(RANDOM_ITEMS, 30, 73);
    test_random(RANDOM_ITEMS, 73, 30);
    test_random(RANDOM_ITEMS, 0, 0);
    operands_if.valid <= 1'b0;
    while (expected_lcm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_saturating_lcm_u64_top: done, clean");
    end else begin
      $display("tb_saturating_lcm_u64_top: done, errors");
    end
    $finish;
  end

endmodule
